// ----- rtl/nrlc_pkg.sv -----
// ----------------------------------------------------------------------------
// nrlc_pkg
// Shared widths, sweep mode codes and the controller/datapath interface types
// of the nested rectangle longest chain unit.
// ----------------------------------------------------------------------------
package nrlc_pkg;

    localparam int SIDE_W            = 16;
    localparam int LEN_W             = 7;
    localparam int POS_W             = 6;
    localparam int S_TDATA_W         = 32;
    localparam int M_TDATA_W         = 16;
    localparam int DEFAULT_MAX_RECTS = 64;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_RELAX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;

    typedef struct packed {
        logic              load;
        logic              pass_init;
        logic              rd_i;
        logic              lat_i;
        logic              sweep_start;
        logic              sweep;
        logic [MODE_W-1:0] mode;
        logic              len_wr;
        logic              take_max;
        logic              emit;
    } nrlc_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic i_last;
        logic any_change;
        logic found;
        logic out_free;
    } nrlc_status_t;

endpackage

// ----- rtl/nrlc_ram.sv -----
// ----------------------------------------------------------------------------
// nrlc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nrlc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/nrlc_datapath.sv -----
// ----------------------------------------------------------------------------
// nrlc_datapath
// Rectangle and chain length stores, sweep counters, nesting compare,
// relaxation, maximum search, successor search and the result register.
// ----------------------------------------------------------------------------
module nrlc_datapath import nrlc_pkg::*; #(
    parameter int MAX_RECTS = DEFAULT_MAX_RECTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nrlc_cmd_t            cmd,
    output nrlc_status_t         status,
    input  logic [S_TDATA_W-1:0] s_tdata,  // rect_width, rect_height
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // chain_length, rect_position, zero pad
    output logic                 m_tlast
);

    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    logic [CNT_W-1:0]  n_reg, n_next, j_reg, j_next;
    logic [IDX_W-1:0]  i_reg, i_next, jd_reg, jd_next;
    logic [IDX_W-1:0]  max_idx_reg, max_idx_next, nxt_reg, nxt_next;
    logic              pend_reg, pend_next, found_reg, found_next;
    logic              changed_reg, changed_next;
    logic [SIDE_W-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [LEN_W-1:0]  ilen_reg, ilen_next, best_reg, best_next;
    logic [LEN_W-1:0]  max_len_reg, max_len_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic              side_we, len_we, upd, nests;
    logic [IDX_W-1:0]  raddr, len_waddr;
    logic [LEN_W-1:0]  len_wdata, len_inc;
    logic [SIDE_W-1:0] rd_a, rd_b;
    logic [LEN_W-1:0]  rd_len;

    assign side_we   = cmd.load && (n_reg < CNT_W'(MAX_RECTS));
    assign upd       = best_reg != ilen_reg;
    assign len_we    = side_we || (cmd.len_wr && upd);
    assign len_waddr = cmd.load ? n_reg[IDX_W-1:0] : i_reg;
    assign len_wdata = cmd.load ? LEN_W'(1) : best_reg;
    assign raddr     = cmd.rd_i ? i_reg : j_reg[IDX_W-1:0];

    nrlc_ram #(.WIDTH(SIDE_W), .DEPTH(MAX_RECTS)) u_side_a (
        .aclk  (aclk),
        .we    (side_we),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (s_tdata[SIDE_W-1:0]),
        .raddr (raddr),
        .rdata (rd_a)
    );

    nrlc_ram #(.WIDTH(SIDE_W), .DEPTH(MAX_RECTS)) u_side_b (
        .aclk  (aclk),
        .we    (side_we),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (s_tdata[2*SIDE_W-1:SIDE_W]),
        .raddr (raddr),
        .rdata (rd_b)
    );

    nrlc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_RECTS)) u_chain_len (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (raddr),
        .rdata (rd_len)
    );

    // rectangle i fits inside rectangle j, either orientation
    assign nests   = ((ia_reg < rd_a) && (ib_reg < rd_b)) ||
                     ((ib_reg < rd_a) && (ia_reg < rd_b));
    assign len_inc = rd_len + LEN_W'(1);

    assign status.sweep_done = (j_reg == n_reg) && !pend_reg;
    assign status.i_last     = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    assign status.any_change = changed_reg || upd;
    assign status.found      = found_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        n_next        = n_reg;
        j_next        = j_reg;
        i_next        = i_reg;
        jd_next       = jd_reg;
        max_idx_next  = max_idx_reg;
        nxt_next      = nxt_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        changed_next  = changed_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        ilen_next     = ilen_reg;
        best_next     = best_reg;
        max_len_next  = max_len_reg;
        m_tvalid_next = m_tvalid_reg;
        out_len_next  = out_len_reg;
        out_pos_next  = out_pos_reg;
        out_last_next = out_last_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (side_we) begin
            n_next = n_reg + CNT_W'(1);
        end

        if (cmd.pass_init) begin
            i_next       = '0;
            changed_next = 1'b0;
            max_len_next = '0;
            max_idx_next = '0;
        end

        if (cmd.lat_i) begin
            ia_next   = rd_a;
            ib_next   = rd_b;
            ilen_next = rd_len;
            best_next = rd_len;
        end

        if (cmd.sweep_start) begin
            j_next       = '0;
            pend_next    = 1'b0;
            found_next   = 1'b0;
        end

        if (cmd.sweep) begin
            if (j_reg != n_reg) begin
                j_next    = j_reg + CNT_W'(1);
                jd_next   = j_reg[IDX_W-1:0];
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg) begin
                case (cmd.mode)
                    MODE_RELAX: begin
                        if (nests && (len_inc > best_reg)) begin
                            best_next = len_inc;
                        end
                    end
                    MODE_MAX: begin
                        if (rd_len > max_len_reg) begin
                            max_len_next = rd_len;
                            max_idx_next = jd_reg;
                        end
                    end
                    MODE_FIND: begin
                        if (!found_reg && nests && (ilen_reg == len_inc)) begin
                            found_next = 1'b1;
                            nxt_next   = jd_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (cmd.len_wr) begin
            if (upd) begin
                changed_next = 1'b1;
            end
            i_next = i_reg + IDX_W'(1);
        end

        if (cmd.take_max) begin
            i_next = max_idx_reg;
        end

        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            out_len_next  = max_len_reg;
            out_pos_next  = POS_W'(i_reg);
            out_last_next = !found_reg;
            if (found_reg) begin
                i_next = nxt_reg;
            end else begin
                n_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            n_reg        <= n_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        i_reg        <= i_next;
        jd_reg       <= jd_next;
        max_idx_reg  <= max_idx_next;
        nxt_reg      <= nxt_next;
        found_reg    <= found_next;
        changed_reg  <= changed_next;
        ia_reg       <= ia_next;
        ib_reg       <= ib_next;
        ilen_reg     <= ilen_next;
        best_reg     <= best_next;
        max_len_reg  <= max_len_next;
        out_len_reg  <= out_len_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - LEN_W - POS_W){1'b0}}, out_pos_reg, out_len_reg};

endmodule

// ----- rtl/nrlc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nrlc_ctrl
// Sequencer for loading, relaxation passes, maximum search and chain walk.
// ----------------------------------------------------------------------------
module nrlc_ctrl import nrlc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    output nrlc_cmd_t    cmd,
    input  nrlc_status_t status
);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_PASS      = 4'd1;
    localparam logic [3:0] S_I_RD      = 4'd2;
    localparam logic [3:0] S_I_LAT     = 4'd3;
    localparam logic [3:0] S_RELAX     = 4'd4;
    localparam logic [3:0] S_I_WR      = 4'd5;
    localparam logic [3:0] S_MAX_START = 4'd6;
    localparam logic [3:0] S_MAX       = 4'd7;
    localparam logic [3:0] S_C_RD      = 4'd8;
    localparam logic [3:0] S_C_LAT     = 4'd9;
    localparam logic [3:0] S_FIND      = 4'd10;
    localparam logic [3:0] S_EMIT      = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.mode   = MODE_RELAX;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS: begin
                cmd.pass_init = 1'b1;
                state_next    = S_I_RD;
            end
            S_I_RD: begin
                cmd.rd_i   = 1'b1;
                state_next = S_I_LAT;
            end
            S_I_LAT: begin
                cmd.lat_i       = 1'b1;
                cmd.sweep_start = 1'b1;
                state_next      = S_RELAX;
            end
            S_RELAX: begin
                cmd.sweep = 1'b1;
                cmd.mode  = MODE_RELAX;
                if (status.sweep_done) begin
                    state_next = S_I_WR;
                end
            end
            S_I_WR: begin
                cmd.len_wr = 1'b1;
                if (status.i_last) begin
                    state_next = status.any_change ? S_PASS : S_MAX_START;
                end else begin
                    state_next = S_I_RD;
                end
            end
            S_MAX_START: begin
                cmd.sweep_start = 1'b1;
                state_next      = S_MAX;
            end
            S_MAX: begin
                cmd.sweep = 1'b1;
                cmd.mode  = MODE_MAX;
                if (status.sweep_done) begin
                    cmd.take_max = 1'b1;
                    state_next   = S_C_RD;
                end
            end
            S_C_RD: begin
                cmd.rd_i   = 1'b1;
                state_next = S_C_LAT;
            end
            S_C_LAT: begin
                cmd.lat_i       = 1'b1;
                cmd.sweep_start = 1'b1;
                state_next      = S_FIND;
            end
            S_FIND: begin
                cmd.sweep = 1'b1;
                cmd.mode  = MODE_FIND;
                if (status.sweep_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.found ? S_C_RD : S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/nested_rectangle_longest_chain_unit.sv -----
// ----------------------------------------------------------------------------
// nested_rectangle_longest_chain_unit
// Finds and streams out the longest chain of nesting rectangles of a set.
// ----------------------------------------------------------------------------
// Rectangles are loaded one per input transfer, with input ready throughout
// loading, the transfer with tlast closing the set; loads past MAX_RECTS are
// dropped. After the set closes, input is held off while chain lengths are
// relaxed pass by pass: each pass visits every rectangle i and sweeps all N
// rectangles through the store read port; passes repeat until one changes
// nothing (at most the longest chain plus one). A maximum search follows, and
// each chain member then has its successor found before it is placed in the
// output register, waiting while the output stalls. After the last member is
// placed there the next set may load.
// ----------------------------------------------------------------------------
module nested_rectangle_longest_chain_unit import nrlc_pkg::*; #(
    parameter int MAX_RECTS = DEFAULT_MAX_RECTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // rect_width, rect_height
    input  logic                 s_tlast,  // set_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // chain_length, rect_position, zero pad
    output logic                 m_tlast   // chain_end
);

    nrlc_cmd_t    cmd;
    nrlc_status_t status;

    nrlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    nrlc_datapath #(.MAX_RECTS(MAX_RECTS)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- dv/tb_nested_rectangle_longest_chain_unit.sv -----
// ----------------------------------------------------------------------------
// tb_nested_rectangle_longest_chain_unit
// Loads sets of rectangles into the unit and checks every streamed chain
// member against a predictor that works out the longest nesting chain of
// each set. The tests cover extreme sides, rotated and equal-side nesting,
// ties, a full store with dropped loads, and random sets of random size.
// ----------------------------------------------------------------------------
module tb_nested_rectangle_longest_chain_unit import nrlc_pkg::*;;

    localparam int MAX_RECTS  = DEFAULT_MAX_RECTS;
    localparam int QUIET_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        logic             last;
    } member_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // rect_width, rect_height
    logic                 s_tlast  = 1'b0;  // set_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // chain_length, rect_position, zero pad
    logic                 m_tlast;  // chain_end

    int send_idle = 0;
    int recv_idle = 0;
    int n_sent    = 0;
    int n_errors  = 0;
    int quiet     = 0;

    // predictor state
    logic [SIDE_W-1:0] side_w [MAX_RECTS];
    logic [SIDE_W-1:0] side_h [MAX_RECTS];
    int                chain_len [MAX_RECTS];
    int                n_loaded = 0;
    member_t           chain_q [$];

    nested_rectangle_longest_chain_unit #(.MAX_RECTS(MAX_RECTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit fits_inside(int i, int j);
        return (side_w[i] < side_w[j] && side_h[i] < side_h[j]) ||
               (side_h[i] < side_w[j] && side_w[i] < side_h[j]);
    endfunction

    function automatic void find_longest_chain(int n);
        bit      changed;
        int      best;
        int      cur;
        int      nxt;
        member_t m;
        for (int i = 0; i < n; i++) chain_len[i] = 1;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    if (fits_inside(i, j) && chain_len[j] + 1 > chain_len[i]) begin
                        chain_len[i] = chain_len[j] + 1;
                        changed = 1'b1;
                    end
                end
            end
        end
        best = 0;
        cur  = 0;
        for (int i = 0; i < n; i++) begin
            if (chain_len[i] > best) begin
                best = chain_len[i];
                cur  = i;
            end
        end
        do begin
            nxt = -1;
            for (int j = 0; j < n && nxt < 0; j++)
                if (fits_inside(cur, j) && chain_len[cur] == chain_len[j] + 1) nxt = j;
            m.len  = LEN_W'(best);
            m.pos  = POS_W'(cur);
            m.last = (nxt < 0);
            chain_q.push_back(m);
            cur = nxt;
        end while (nxt >= 0);
    endfunction

    function automatic void track_rect(logic [SIDE_W-1:0] w, h, logic set_end);
        if (n_loaded < MAX_RECTS) begin
            side_w[n_loaded] = w;
            side_h[n_loaded] = h;
            n_loaded++;
        end
        if (set_end) begin
            find_longest_chain(n_loaded);
            n_loaded = 0;
        end
    endfunction

    task automatic send_rect(input logic [SIDE_W-1:0] w, h, input logic set_end);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h, w};
        s_tlast  <= set_end;
        do @(posedge aclk); while (!s_tready);
        track_rect(w, h, set_end);
        n_sent++;
    endtask

    // k stored rectangles, then extra loads that land on a full store;
    // style 0: loose chain, 1: tiny sides, 2: any sides, 3: strict chain
    task automatic send_random_set(input int k, input int extra, input int style);
        logic [SIDE_W-1:0] ws [MAX_RECTS];
        logic [SIDE_W-1:0] hs [MAX_RECTS];
        logic [SIDE_W-1:0] t;
        int                j;
        int                step_lo;
        step_lo = (style == 3) ? 1 : 0;
        ws[0] = SIDE_W'($urandom_range(0, 65535 - 4 * k));
        hs[0] = SIDE_W'($urandom_range(0, 65535 - 4 * k));
        for (int i = 0; i < k; i++) begin
            if (i > 0) begin
                ws[i] = ws[i-1] + SIDE_W'($urandom_range(step_lo, 3));
                hs[i] = hs[i-1] + SIDE_W'($urandom_range(step_lo, 3));
            end
            if (style == 1) begin
                ws[i] = SIDE_W'($urandom_range(0, 15));
                hs[i] = SIDE_W'($urandom_range(0, 15));
            end else if (style == 2) begin
                ws[i] = SIDE_W'($urandom);
                hs[i] = SIDE_W'($urandom);
            end
        end
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(1)) begin
                t = ws[i];
                ws[i] = hs[i];
                hs[i] = t;
            end
        end
        for (int i = k - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ws[i]; ws[i] = ws[j]; ws[j] = t;
            t = hs[i]; hs[i] = hs[j]; hs[j] = t;
        end
        for (int i = 0; i < k; i++) send_rect(ws[i], hs[i], extra == 0 && i == k - 1);
        for (int e = 0; e < extra; e++)
            send_rect(SIDE_W'($urandom), SIDE_W'($urandom), e == extra - 1);
    endtask

    task automatic test_extreme_sides();
        send_rect(16'd0, 16'd0, 1'b1);
        send_rect(16'hffff, 16'hffff, 1'b1);
        send_rect(16'd0, 16'd0, 1'b0);
        send_rect(16'hffff, 16'hffff, 1'b1);
        send_rect(16'hffff, 16'd0, 1'b0);
        send_rect(16'd0, 16'hffff, 1'b1);
    endtask

    task automatic test_rotation_and_equal_sides();
        // nests only when rotated
        send_rect(16'd5, 16'd1, 1'b0);
        send_rect(16'd2, 16'd6, 1'b1);
        // one equal side never nests
        send_rect(16'd3, 16'd5, 1'b0);
        send_rect(16'd3, 16'd6, 1'b1);
    endtask

    task automatic test_ties();
        send_rect(16'd4, 16'd4, 1'b0);
        send_rect(16'd4, 16'd4, 1'b0);
        send_rect(16'd4, 16'd4, 1'b1);
        // two successors of equal length
        send_rect(16'd1, 16'd1, 1'b0);
        send_rect(16'd9, 16'd2, 1'b0);
        send_rect(16'd2, 16'd9, 1'b0);
        send_rect(16'd10, 16'd10, 1'b1);
        // one chain of four, loaded out of size order
        send_rect(16'd5, 16'd5, 1'b0);
        send_rect(16'd6, 16'd6, 1'b0);
        send_rect(16'd1, 16'd1, 1'b0);
        send_rect(16'd2, 16'd2, 1'b1);
    endtask

    task automatic test_store_full();
        send_random_set(MAX_RECTS, 2, 3);
        send_random_set(MAX_RECTS, 1, 0);
    endtask

    task automatic test_random_sets(input int upto);
        int k;
        int style;
        while (n_sent < upto) begin
            case ($urandom_range(19))
                0:         k = $urandom_range(17, 30);
                1, 2, 3,
                4, 5:      k = $urandom_range(7, 16);
                default:   k = $urandom_range(1, 6);
            endcase
            case ($urandom_range(9))
                0, 1, 2,
                3, 4:      style = 0;
                5, 6, 7:   style = 1;
                default:   style = 2;
            endcase
            send_random_set(k, 0, style);
        end
    endtask

    // result check and receiver stalls
    always @(posedge aclk) begin
        member_t exp_m;
        logic    bad;
        if (aresetn && m_tvalid && m_tready) begin
            if (chain_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: len %0d pos %0d last %0d",
                             m_tdata[LEN_W-1:0], m_tdata[LEN_W+POS_W-1:LEN_W], m_tlast);
            end else begin
                exp_m = chain_q.pop_front();
                bad = (m_tdata[LEN_W-1:0] !== exp_m.len) ||
                      (m_tdata[LEN_W+POS_W-1:LEN_W] !== exp_m.pos) ||
                      (m_tdata[M_TDATA_W-1:LEN_W+POS_W] !== '0) ||
                      (m_tlast !== exp_m.last);
                if (bad) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected len %0d pos %0d last %0d, got tdata %h last %0d",
                                 exp_m.len, exp_m.pos, exp_m.last, m_tdata, m_tlast);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 23;
        recv_idle = 79;
        test_extreme_sides();
        test_rotation_and_equal_sides();
        test_ties();
        test_random_sets(160);

        send_idle = 79;
        recv_idle = 23;
        test_random_sets(300);

        send_idle = 0;
        recv_idle = 0;
        test_store_full();
        test_random_sets(460);

        s_tvalid <= 1'b0;
        while (chain_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0 && chain_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/nrlc_pkg.sv
rtl/nrlc_ram.sv
rtl/nrlc_datapath.sv
rtl/nrlc_ctrl.sv
rtl/nested_rectangle_longest_chain_unit.sv
dv/tb_nested_rectangle_longest_chain_unit.sv
